// ===== rtl/lpg_pkg.sv =====
`default_nettype none

package lpg_pkg;

  localparam int MAX_LEN    = 8;
  localparam int NIB_W      = 4;
  localparam int IDX_W      = 3;
  localparam int LEN_W      = 4;
  localparam int SEQ_W      = 16;
  localparam int PERM_W     = MAX_LEN * NIB_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PERM_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = CFG_IDX_W'(1);

  // Reset values of the configuration registers.
  localparam logic [LEN_W-1:0]  PERM_LEN_RST = LEN_W'(MAX_LEN);
  localparam logic [PERM_W-1:0] TARGET_RST   = 32'h3718_5462;

  // Control of the permutation register file by the sequencer.
  typedef struct packed {
    logic             load;
    logic [LEN_W-1:0] load_len;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [NIB_W-1:0] wr_data;
  } pf_ctrl_t;

  // One result as produced by the sequencer.
  typedef struct packed {
    logic [SEQ_W-1:0]  seq_number;
    logic [PERM_W-1:0] perm_packed;
    logic              is_target;
    logic              is_final;
  } emit_t;

  // Clamps a length register to the range 1..MAX_LEN.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_LEN)) begin
      res = LEN_W'(MAX_LEN);
    end
    return res;
  endfunction

  // Identity permutation 1..len, packed, with the unused nibbles zero.
  function automatic logic [PERM_W-1:0] identity(input logic [LEN_W-1:0] len);
    logic [PERM_W-1:0] res;
    res = '0;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (LEN_W'(i) < len) begin
        res[i*NIB_W +: NIB_W] = NIB_W'(i + 1);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lexicographic_permutation_generator_core.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ---------------------------------------
// in        sink       in_valid_i / in_stall_o   restart_i
// out       source     out_valid_o / out_stall_i seq_number_o, perm_packed_o,
//                                                is_target_o, is_final_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request occupies the sequencer from its acceptance in the idle state onwards. The
// steps are one priming read, a right-to-left scan for the ascent, the hand-over of
// the result (which waits for the output register), a scan for the swap partner and
// one swap. After those come the tail reversal, pair by pair (check and read the low
// element, read the high one, write the low one, write the high one), and one closing
// check; a final result ends the request at hand-over. The pace is set by the single
// read and write port of the permutation register file and the one shared comparator.
// A request while halted produces no result.
// Reset (rst_ni low, asynchronous) loads the identity of length eight and the
// default target. A stalled result sits in the output register while the next
// request is accepted; the sequencer only waits if it reaches hand-over before
// the previous result has been taken.

module lexicographic_permutation_generator_core
  import lpg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  restart_i,
  // Result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SEQ_W-1:0]           seq_number_o,
  output logic [PERM_W-1:0]          perm_packed_o,
  output logic                       is_target_o,
  output logic                       is_final_o,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [LEN_W-1:0]  perm_len_q;
  logic [PERM_W-1:0] target_q;
  logic              cfg_we;
  logic              cfg_restart;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  ld_len;

  logic              idle;
  logic              start;
  pf_ctrl_t          pf_ctrl;
  logic [NIB_W-1:0]  rd_data;
  logic [PERM_W-1:0] view;
  logic              emit_valid;
  logic              emit_ready;
  emit_t             emit;

  logic              out_valid_q;
  emit_t             out_q;

  // Requests and configuration writes are only taken while the sequencer is idle.
  // A pending register write goes first, so the two are never taken together.
  assign in_stall_o  = !idle || cfg_valid_i;
  assign cfg_ready_o = idle;
  assign start       = in_valid_i && !in_stall_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_we && (cfg_index_i == REG_PERM_LEN);

  // The working length is the clamped register value; a length write restarts the
  // enumeration with the newly written length in the same cycle.
  assign len    = eff_len(perm_len_q);
  assign ld_len = cfg_restart ? eff_len(cfg_data_i[LEN_W-1:0]) : len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_len_q <= PERM_LEN_RST;
      target_q   <= TARGET_RST;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_PERM_LEN: perm_len_q <= cfg_data_i[LEN_W-1:0];
        REG_TARGET:   target_q   <= cfg_data_i[PERM_W-1:0];
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

  lpg_perm_file u_perm_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pf_ctrl),
    .rd_data_o (rd_data),
    .view_o    (view)
  );

  lpg_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .restart_i     (restart_i),
    .cfg_restart_i (cfg_restart),
    .len_i         (len),
    .ld_len_i      (ld_len),
    .target_i      (target_q),
    .view_i        (view),
    .rd_data_i     (rd_data),
    .pf_ctrl_o     (pf_ctrl),
    .idle_o        (idle),
    .emit_valid_o  (emit_valid),
    .emit_ready_i  (emit_ready),
    .emit_o        (emit)
  );

  // Output register: it takes a new result whenever it is empty or being emptied.
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid && emit_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_q <= emit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign seq_number_o  = out_q.seq_number;
  assign perm_packed_o = out_q.perm_packed;
  assign is_target_o   = out_q.is_target;
  assign is_final_o    = out_q.is_final;

endmodule

`default_nettype wire

// ===== rtl/lpg_perm_file.sv =====
`default_nettype none

module lpg_perm_file
  import lpg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pf_ctrl_t          ctrl_i,
  output logic [NIB_W-1:0]       rd_data_o,
  output logic [PERM_W-1:0]      view_o
);

  logic [NIB_W-1:0] perm_q [MAX_LEN];
  logic [NIB_W-1:0] rd_data_q;
  logic [PERM_W-1:0] ident;

  assign ident = identity(ctrl_i.load_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        perm_q[i] <= NIB_W'(i + 1);
      end
    end else if (ctrl_i.load) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        perm_q[i] <= ident[i*NIB_W +: NIB_W];
      end
    end else if (ctrl_i.wr_en) begin
      perm_q[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
  end

  // Single registered read port for the sequencer.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= perm_q[ctrl_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      view_o[i*NIB_W +: NIB_W] = perm_q[i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lpg_seq.sv =====
`default_nettype none

module lpg_seq
  import lpg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              restart_i,
  input  wire logic              cfg_restart_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic [LEN_W-1:0]  ld_len_i,
  input  wire logic [PERM_W-1:0] target_i,
  input  wire logic [PERM_W-1:0] view_i,
  input  wire logic [NIB_W-1:0]  rd_data_i,
  output pf_ctrl_t               pf_ctrl_o,
  output logic                   idle_o,
  output logic                   emit_valid_o,
  input  wire logic              emit_ready_i,
  output emit_t                  emit_o
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_PRIME     = 10'b00_0000_0010,
    ST_SCAN      = 10'b00_0000_0100,
    ST_EMIT      = 10'b00_0000_1000,
    ST_FIND      = 10'b00_0001_0000,
    ST_SWAP      = 10'b00_0010_0000,
    ST_REV_CHK   = 10'b00_0100_0000,
    ST_REV_RD_HI = 10'b00_1000_0000,
    ST_REV_WR_LO = 10'b01_0000_0000,
    ST_REV_WR_HI = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [IDX_W-1:0] a_q, a_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [NIB_W-1:0] hold_q, hold_d;
  logic [NIB_W-1:0] va_q, va_d;
  logic [NIB_W-1:0] t_q, t_d;
  logic             pair_q, pair_d;
  logic             found_q, found_d;
  logic [SEQ_W-1:0] count_q, count_d;
  logic             seen_q, seen_d;
  logic             halted_q, halted_d;

  logic [IDX_W-1:0] last_idx;
  logic [NIB_W-1:0] cmp_a, cmp_b;
  logic             lt;
  logic             match;
  logic             final_flag;

  assign last_idx = IDX_W'(len_i - LEN_W'(1));

  // The one shared comparator: scan for the ascent, then the swap partner.
  always_comb begin
    cmp_a = va_q;
    cmp_b = rd_data_i;
    if (state_q == ST_SCAN) begin
      cmp_a = rd_data_i;
      cmp_b = hold_q;
    end
  end
  assign lt = cmp_a < cmp_b;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_LEN; i++) begin
      if (LEN_W'(i) < len_i &&
          target_i[i*NIB_W +: NIB_W] != view_i[i*NIB_W +: NIB_W]) begin
        match = 1'b0;
      end
    end
  end

  assign final_flag   = seen_q || !found_q;
  assign idle_o       = (state_q == ST_IDLE);
  assign emit_valid_o = (state_q == ST_EMIT);

  assign emit_o.seq_number  = count_q + SEQ_W'(1);
  assign emit_o.perm_packed = view_i;
  assign emit_o.is_target   = match;
  assign emit_o.is_final    = final_flag;

  always_comb begin
    state_d  = state_q;
    ridx_d   = ridx_q;
    a_d      = a_q;
    j_d      = j_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    hold_d   = hold_q;
    va_d     = va_q;
    t_d      = t_q;
    pair_d   = pair_q;
    found_d  = found_q;
    count_d  = count_q;
    seen_d   = seen_q;
    halted_d = halted_q;
    pf_ctrl_o = '0;
    pf_ctrl_o.load_len = len_i;

    case (state_q)
      ST_IDLE: begin
        if (cfg_restart_i) begin
          pf_ctrl_o.load     = 1'b1;
          pf_ctrl_o.load_len = ld_len_i;
          count_d  = '0;
          seen_d   = 1'b0;
          halted_d = 1'b0;
        end else if (start_i) begin
          if (restart_i) begin
            pf_ctrl_o.load = 1'b1;
            count_d  = '0;
            seen_d   = 1'b0;
            halted_d = 1'b0;
            state_d  = ST_PRIME;
          end else if (!halted_q) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        pf_ctrl_o.rd_en   = 1'b1;
        pf_ctrl_o.rd_addr = last_idx;
        ridx_d = last_idx;
        pair_d = 1'b0;
        if (len_i == LEN_W'(1)) begin
          found_d = 1'b0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pair_q && lt) begin
          found_d = 1'b1;
          a_d     = ridx_q;
          va_d    = rd_data_i;
          state_d = ST_EMIT;
        end else if (ridx_q == '0) begin
          found_d = 1'b0;
          state_d = ST_EMIT;
        end else begin
          pf_ctrl_o.rd_en   = 1'b1;
          pf_ctrl_o.rd_addr = ridx_q - IDX_W'(1);
          hold_d = rd_data_i;
          ridx_d = ridx_q - IDX_W'(1);
          pair_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_ready_i) begin
          count_d = count_q + SEQ_W'(1);
          if (match) begin
            seen_d = 1'b1;
          end
          if (final_flag) begin
            halted_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            pf_ctrl_o.rd_en   = 1'b1;
            pf_ctrl_o.rd_addr = last_idx;
            j_d     = last_idx;
            state_d = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (lt) begin
          pf_ctrl_o.wr_en   = 1'b1;
          pf_ctrl_o.wr_addr = a_q;
          pf_ctrl_o.wr_data = rd_data_i;
          state_d = ST_SWAP;
        end else begin
          pf_ctrl_o.rd_en   = 1'b1;
          pf_ctrl_o.rd_addr = j_q - IDX_W'(1);
          j_d = j_q - IDX_W'(1);
        end
      end
      ST_SWAP: begin
        pf_ctrl_o.wr_en   = 1'b1;
        pf_ctrl_o.wr_addr = j_q;
        pf_ctrl_o.wr_data = va_q;
        lo_d    = a_q + IDX_W'(1);
        hi_d    = last_idx;
        state_d = ST_REV_CHK;
      end
      ST_REV_CHK: begin
        if (lo_q < hi_q) begin
          pf_ctrl_o.rd_en   = 1'b1;
          pf_ctrl_o.rd_addr = lo_q;
          state_d = ST_REV_RD_HI;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REV_RD_HI: begin
        pf_ctrl_o.rd_en   = 1'b1;
        pf_ctrl_o.rd_addr = hi_q;
        t_d     = rd_data_i;
        state_d = ST_REV_WR_LO;
      end
      ST_REV_WR_LO: begin
        pf_ctrl_o.wr_en   = 1'b1;
        pf_ctrl_o.wr_addr = lo_q;
        pf_ctrl_o.wr_data = rd_data_i;
        state_d = ST_REV_WR_HI;
      end
      ST_REV_WR_HI: begin
        pf_ctrl_o.wr_en   = 1'b1;
        pf_ctrl_o.wr_addr = hi_q;
        pf_ctrl_o.wr_data = t_q;
        lo_d    = lo_q + IDX_W'(1);
        hi_d    = hi_q - IDX_W'(1);
        state_d = ST_REV_CHK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      seen_q   <= 1'b0;
      halted_q <= 1'b0;
      pair_q   <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
      halted_q <= halted_d;
      pair_q   <= pair_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    a_q    <= a_d;
    j_q    <= j_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    hold_q <= hold_d;
    va_q   <= va_d;
    t_q    <= t_d;
  end

  // A request that arrives while halted, without restart, yields nothing.
  a_halted_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_o && start_i && !restart_i && !cfg_restart_i && halted_q) |=> idle_o)
    else $error("request accepted while halted left idle");

  // Each delivered result advances the sequence count by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && emit_ready_i) |=> count_q == SEQ_W'($past(count_q) + SEQ_W'(1)))
    else $error("sequence count did not advance by one");

  // The swap partner always lies to the right of the ascent.
  a_find_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIND) |-> (j_q > a_q))
    else $error("swap search ran past the ascent");

  // Halting only follows the delivery of a final result.
  a_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> $past(emit_valid_o && emit_ready_i && emit_o.is_final))
    else $error("halted without a final result");

endmodule

`default_nettype wire

// ===== tb/lexicographic_permutation_generator_core_test.sv =====
module lexicographic_permutation_generator_core_test;
  import lpg_pkg::*;

  // Each side idles in roughly this share of cycles, in per cent.
  localparam int IDLE_PCT       = 36;
  // Cycles with no transfer on any channel before the run is declared hung. The
  // longest planned hold-off is far shorter than this, so only a real hang can
  // get here.
  localparam int WATCHDOG_LIMIT = 3000;
  // Quiet cycles after the last expected result. The sequencer may still be
  // stepping to the successor permutation, or swallowing a request while
  // halted, so we let that finish before touching the registers.
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 200;
  localparam int REQUEST_GOAL   = 1450;

  // The interface has only two real register indexes. Index three decodes to
  // nothing and must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  req_valid   = 1'b0;
  logic                  req_restart = 1'b0;
  logic                  req_stall;
  logic                  res_valid;
  logic                  res_stall   = 1'b0;
  logic [SEQ_W-1:0]      res_seq;
  logic [PERM_W-1:0]     res_perm;
  logic                  res_target;
  logic                  res_final;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  lexicographic_permutation_generator_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_stall_o    (req_stall),
    .restart_i     (req_restart),
    .out_valid_o   (res_valid),
    .out_stall_i   (res_stall),
    .seq_number_o  (res_seq),
    .perm_packed_o (res_perm),
    .is_target_o   (res_target),
    .is_final_o    (res_final),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending requests (the restart bit of each) and results still owed by the block.
  bit    request_queue[$];
  emit_t expected_emits[$];

  // Our own copy of the enumerator: configuration and running state.
  logic [LEN_W-1:0]  len_reg    = PERM_LEN_RST;
  logic [PERM_W-1:0] target_reg = TARGET_RST;
  logic [PERM_W-1:0] cur_perm;
  logic [SEQ_W-1:0]  emitted;
  bit                target_hit;
  bit                stopped;

  // Traffic shaping, set by the stimulus process only.
  bit calm;
  bit hold_arm;

  int errors;
  int requests_sent;
  int results_predicted;
  int results_checked;
  int targets_seen;
  int finals_seen;
  int cfg_writes;
  int phase_count;
  bit [15:0] lens_written;

  // ---------------------------------------------------------------------------
  // Enumerator model
  // ---------------------------------------------------------------------------

  // A length of zero behaves as one, anything above the maximum as the maximum.
  function automatic int clamp_length(input logic [LEN_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > LEN_W'(MAX_LEN)) return MAX_LEN;
    return int'(raw);
  endfunction

  function automatic logic [PERM_W-1:0] identity_perm(input int n);
    logic [PERM_W-1:0] p;
    p = '0;
    for (int i = 0; i < n; i++) p[i*NIB_W +: NIB_W] = NIB_W'(i + 1);
    return p;
  endfunction

  // Position of the rightmost ascent, or -1 for the last permutation.
  function automatic int rightmost_ascent(input logic [PERM_W-1:0] p, input int n);
    for (int i = n - 2; i >= 0; i--) begin
      if (p[i*NIB_W +: NIB_W] < p[(i+1)*NIB_W +: NIB_W]) return i;
    end
    return -1;
  endfunction

  // Standard successor step: swap the ascent's left element with the rightmost
  // larger element, then reverse everything to its right.
  function automatic logic [PERM_W-1:0] successor(input logic [PERM_W-1:0] p, input int n,
                                                  input int a);
    logic [NIB_W-1:0] t;
    int j;
    int lo;
    int hi;
    j = n - 1;
    while (j > a && p[j*NIB_W +: NIB_W] <= p[a*NIB_W +: NIB_W]) j--;
    t = p[a*NIB_W +: NIB_W];
    p[a*NIB_W +: NIB_W] = p[j*NIB_W +: NIB_W];
    p[j*NIB_W +: NIB_W] = t;
    lo = a + 1;
    hi = n - 1;
    while (lo < hi) begin
      t = p[lo*NIB_W +: NIB_W];
      p[lo*NIB_W +: NIB_W] = p[hi*NIB_W +: NIB_W];
      p[hi*NIB_W +: NIB_W] = t;
      lo++;
      hi--;
    end
    return p;
  endfunction

  function automatic logic [PERM_W-1:0] steps_ahead(input logic [PERM_W-1:0] p, input int n,
                                                    input int k);
    int a;
    for (int s = 0; s < k; s++) begin
      a = rightmost_ascent(p, n);
      if (a < 0) break;
      p = successor(p, n, a);
    end
    return p;
  endfunction

  task automatic restart_enumeration();
    cur_perm   = identity_perm(clamp_length(len_reg));
    emitted    = '0;
    target_hit = 1'b0;
    stopped    = 1'b0;
  endtask

  // Works out what one accepted request produces, and moves the model on.
  task automatic advance_enumerator(input logic restart, output bit produced,
                                    output emit_t res);
    int n;
    int a;
    bit hit;
    bit fin;
    n        = clamp_length(len_reg);
    produced = 1'b0;
    res      = '0;
    if (restart) restart_enumeration();
    if (stopped) return;
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (target_reg[i*NIB_W +: NIB_W] != cur_perm[i*NIB_W +: NIB_W]) hit = 1'b0;
    end
    emitted = emitted + 1'b1;
    a       = rightmost_ascent(cur_perm, n);
    // The result after a target match ends the run, as does the last permutation.
    fin     = target_hit || (a < 0);
    res.seq_number  = emitted;
    res.perm_packed = cur_perm;
    res.is_target   = hit;
    res.is_final    = fin;
    if (hit) target_hit = 1'b1;
    if (fin) begin
      stopped = 1'b1;
    end else begin
      cur_perm = successor(cur_perm, n, a);
    end
    produced = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: presents the head of the queue and removes it once taken.
  // The head only leaves the queue on acceptance, so the stimulus process can
  // tell from the queue and the valid line alone whether anything is in flight.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    bit    produced;
    emit_t res;
    bit    take;
    bit    next_valid;
    if (rst_n) begin
      take       = req_valid && !req_stall;
      next_valid = req_valid && !take;
      if (take) begin
        void'(request_queue.pop_front());
        requests_sent++;
        advance_enumerator(req_restart, produced, res);
        if (produced) begin
          expected_emits.push_back(res);
          results_predicted++;
        end
      end
      if (!next_valid && request_queue.size() != 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_valid  = 1'b1;
        req_restart <= request_queue[0];
      end
      req_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure. When the stimulus arms the hold-off, the stall is
  // held for a long stretch so that the output register and then the request
  // port fill up; the count is kept here, not in the stimulus process.
  // ---------------------------------------------------------------------------
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transferred result is matched against the oldest
  // outstanding expectation, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [PERM_W-1:0] want,
                             input logic [PERM_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    emit_t want;
    if (rst_n && res_valid && !res_stall) begin
      if (expected_emits.size() == 0) begin
        $error("unexpected result: seq_number %0d, perm_packed %h", res_seq, res_perm);
        errors++;
      end else begin
        want = expected_emits.pop_front();
        check_field("seq_number", PERM_W'(want.seq_number), PERM_W'(res_seq));
        check_field("perm_packed", want.perm_packed, res_perm);
        check_field("is_target", PERM_W'(want.is_target), PERM_W'(res_target));
        check_field("is_final", PERM_W'(want.is_final), PERM_W'(res_final));
        results_checked++;
        if (want.is_target) targets_seen++;
        if (want.is_final) finals_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel counts as progress.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_emits.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Register writes are only issued while the block is idle, so the model can
  // take them on at the moment of the handshake.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == REG_PERM_LEN) begin
      // Writing the length starts the enumeration afresh.
      len_reg = data[LEN_W-1:0];
      lens_written[data[LEN_W-1:0]] = 1'b1;
      restart_enumeration();
    end else if (idx == REG_TARGET) begin
      target_reg = data;
    end
  endtask

  task automatic wait_until_drained();
    do @(posedge clk);
    while (request_queue.size() != 0 || req_valid || expected_emits.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_requests(input int count, input int restart_pct, input bit restart_first);
    for (int i = 0; i < count; i++) begin
      request_queue.push_back((i == 0 && restart_first) || $urandom_range(99) < restart_pct);
    end
  endtask

  // One random phase. Most phases aim the target a known number of steps ahead
  // of where the enumeration will start, so that the match and the final result
  // really happen; the rest use a noisy target, keep the old one, or poke the
  // unused register index.
  task automatic random_phase();
    int                n_raw;
    int                n;
    int                k;
    int                kind;
    int                count;
    bit                fresh;
    logic [PERM_W-1:0] tgt;
    logic [PERM_W-1:0] junk;
    logic [31:0]       upper;
    wait_until_drained();
    kind = $urandom_range(9);
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(9))
        0:       n_raw = 0;
        1:       n_raw = $urandom_range(15, 9);
        default: n_raw = $urandom_range(8, 1);
      endcase
      // The upper data bits carry nothing for the length register.
      upper = $urandom;
      write_register(REG_PERM_LEN, {upper[CFG_DATA_W-1:LEN_W], LEN_W'(n_raw)});
    end
    n     = clamp_length(len_reg);
    fresh = stopped || $urandom_range(1) == 0;
    k     = $urandom_range(40);
    if (kind <= 5) begin
      tgt  = steps_ahead(fresh ? identity_perm(n) : cur_perm, n, k);
      junk = $urandom;
      // Nibbles beyond the length are never compared, so fill them with noise.
      for (int i = n; i < MAX_LEN; i++) tgt[i*NIB_W +: NIB_W] = junk[i*NIB_W +: NIB_W];
      write_register(REG_TARGET, tgt);
      count = k + 2 + $urandom_range(2);
      queue_requests(count, 2, fresh);
    end else begin
      if (kind <= 7) begin
        write_register(REG_TARGET, $urandom);
      end else if (kind == 9) begin
        write_register(REG_UNUSED, $urandom);
      end
      queue_requests($urandom_range(30, 3), 10, fresh);
    end
  endtask

  initial begin
    restart_enumeration();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Defaults straight out of reset, then a restart request.
    queue_requests(3, 0, 1'b0);
    request_queue.push_back(1'b1);
    wait_until_drained();

    // Single element: one final result, a request while halted that yields
    // nothing, then a restart that brings the result back.
    write_register(REG_PERM_LEN, CFG_DATA_W'(1));
    queue_requests(2, 0, 1'b0);
    request_queue.push_back(1'b1);
    wait_until_drained();

    // A length of zero behaves as one; here the lone element is also the target.
    write_register(REG_PERM_LEN, '0);
    write_register(REG_TARGET, CFG_DATA_W'(1));
    queue_requests(1, 0, 1'b0);
    wait_until_drained();

    // An oversized length behaves as eight; the target is the second permutation,
    // so the third result is final and the fourth request is swallowed.
    write_register(REG_PERM_LEN, CFG_DATA_W'(15));
    write_register(REG_TARGET, 32'h7865_4321);
    queue_requests(4, 0, 1'b0);
    wait_until_drained();

    // A target that is no permutation at all: run three elements to the end.
    write_register(REG_PERM_LEN, CFG_DATA_W'(3));
    write_register(REG_TARGET, '0);
    queue_requests(7, 0, 1'b0);
    wait_until_drained();

    // Two elements with an all-ones target: the last permutation ends the run.
    write_register(REG_PERM_LEN, CFG_DATA_W'(2));
    write_register(REG_TARGET, '1);
    queue_requests(3, 0, 1'b0);

    // Random part, with three special phases mixed in.
    while (requests_sent + request_queue.size() < REQUEST_GOAL) begin
      phase_count++;
      if (phase_count == 5) begin
        // A long stretch with no idling on either side.
        wait_until_drained();
        calm = 1'b1;
        write_register(REG_PERM_LEN, CFG_DATA_W'(8));
        write_register(REG_TARGET, $urandom);
        queue_requests(150, 0, 1'b1);
        wait_until_drained();
        calm = 1'b0;
      end else if (phase_count == 10) begin
        // The receiver holds off for a long time while requests keep coming.
        wait_until_drained();
        write_register(REG_PERM_LEN, CFG_DATA_W'(8));
        write_register(REG_TARGET, $urandom);
        hold_arm = 1'b1;
        queue_requests(40, 0, 1'b1);
      end else if (phase_count == 15) begin
        // The sender pauses mid-phase until every result is in, then carries on.
        wait_until_drained();
        queue_requests(12, 0, 1'b1);
        wait_until_drained();
        queue_requests(12, 0, 1'b0);
      end else begin
        random_phase();
      end
    end

    wait_until_drained();
    $display("Coverage: %0d requests, %0d register writes, %0d phases, lengths written %h.",
             requests_sent, cfg_writes, phase_count, lens_written);
    $display("Checked %0d results, %0d target matches, %0d final results, %0d errors.",
             results_checked, targets_seen, finals_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
